### rtl/imuds_pkg.sv
// Shared types, constants and the smoothing function for the IMU sample decoder.
`timescale 1ns / 1ps

package imuds_pkg;

	// Axis value width as reported on the result stream.
	localparam int AXIS_W = 12;
	// Stored magnetometer width.
	localparam int MAG_W = 11;
	// Width of one smoothing weight.
	localparam int K_W = 8;
	// Configuration index width on the write channel.
	localparam int CFG_IDX_W = 8;

	// Magnetometer acceptance window; both limits are exclusive.
	localparam logic signed [15:0] MAG_LIMIT_HI = 16'sh03FF;
	localparam logic signed [15:0] MAG_LIMIT_LO = -16'sh0400;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SMOOTHING  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGNET_SMOOTHING = 8'd1;

	// Sensor selector carried with each word.
	localparam logic SENSOR_ACCEL  = 1'b0;
	localparam logic SENSOR_MAGNET = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_XFER_ERR = 2'd1,
		STATUS_RANGE    = 2'd2
	} status_t;

	typedef logic signed [AXIS_W-1:0] axis_t;

	// One decoded sensor read.
	typedef struct packed {
		axis_t x;
		axis_t y;
		axis_t z;
		logic  mag_ok;
	} decode_t;

	// Update request from the top level to the filter state.
	typedef struct packed {
		logic update;
		logic sensor;
	} filt_ctl_t;

	// First-order smoothing: (256*x - k*(x - old)) >> 8 with floor, bypassed when k is 0.
	// The result always lies between x and old, so bits 19:8 of the sum hold it.
	function automatic axis_t smooth(input axis_t x, input axis_t old, input logic [K_W-1:0] k);
		logic signed [AXIS_W:0]   diff;
		logic signed [AXIS_W+K_W+1:0] prod;
		logic signed [23:0]       acc;
		diff = {x[AXIS_W-1], x} - {old[AXIS_W-1], old};
		prod = $signed({1'b0, k}) * diff;
		acc  = {{4{x[AXIS_W-1]}}, x, 8'h00} - {{2{prod[AXIS_W+K_W+1]}}, prod};
		if (k == '0) begin
			return x;
		end
		return acc[19:8];
	endfunction

endpackage

### rtl/imuds_decode.sv
// Byte decoder: turns six raw bytes into three signed axis values and a range flag.
`timescale 1ns / 1ps

module imuds_decode (
	input  logic                  sensor,
	input  logic [47:0]           raw,
	output imuds_pkg::decode_t    dec
);

	logic [15:0]        le_word [3];
	logic signed [15:0] be_word [3];
	logic [2:0]         in_range;
	imuds_pkg::axis_t   val [3];

	// Per axis: accelerometer words are little-endian and left-justified,
	// magnetometer words are big-endian 16-bit values.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			le_word[i]  = {raw[16*i+8 +: 8], raw[16*i +: 8]};
			be_word[i]  = $signed({raw[16*i +: 8], raw[16*i+8 +: 8]});
			in_range[i] = (be_word[i] < imuds_pkg::MAG_LIMIT_HI) &&
				(be_word[i] > imuds_pkg::MAG_LIMIT_LO);
			if (sensor == imuds_pkg::SENSOR_MAGNET) begin
				val[i] = be_word[i][imuds_pkg::AXIS_W-1:0];
			end else begin
				val[i] = le_word[i][15:4];
			end
		end
	end

	assign dec.x      = val[0];
	assign dec.y      = val[1];
	assign dec.z      = val[2];
	assign dec.mag_ok = &in_range;

endmodule

### rtl/imuds_smooth.sv
// Filter state for both sensors with the per-axis smoothing update.
`timescale 1ns / 1ps

module imuds_smooth (
	input  logic                           clk,
	input  logic                           arst_n,
	input  imuds_pkg::filt_ctl_t           ctl,
	input  imuds_pkg::decode_t             dec,
	input  logic [imuds_pkg::K_W-1:0]      accel_k,
	input  logic [imuds_pkg::K_W-1:0]      magnet_k,
	output imuds_pkg::axis_t               axis_x,
	output imuds_pkg::axis_t               axis_y,
	output imuds_pkg::axis_t               axis_z
);

	imuds_pkg::axis_t                     accel_q [3];
	logic signed [imuds_pkg::MAG_W-1:0]   magnet_q [3];
	imuds_pkg::axis_t                     sample [3];
	imuds_pkg::axis_t                     old_val [3];
	imuds_pkg::axis_t                     new_val [3];
	imuds_pkg::axis_t                     shown [3];
	logic [imuds_pkg::K_W-1:0]            k_sel;

	assign sample[0] = dec.x;
	assign sample[1] = dec.y;
	assign sample[2] = dec.z;
	assign k_sel = (ctl.sensor == imuds_pkg::SENSOR_MAGNET) ? magnet_k : accel_k;

	// One multiply per axis against the addressed sensor's stored value.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ctl.sensor == imuds_pkg::SENSOR_MAGNET) begin
				old_val[i] = {magnet_q[i][imuds_pkg::MAG_W-1], magnet_q[i]};
			end else begin
				old_val[i] = accel_q[i];
			end
			new_val[i] = imuds_pkg::smooth(sample[i], old_val[i], k_sel);
			shown[i]   = ctl.update ? new_val[i] : old_val[i];
		end
	end

	// State update on an accepted, error-free, in-range read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				accel_q[i]  <= '0;
				magnet_q[i] <= '0;
			end
		end else if (ctl.update) begin
			for (int i = 0; i < 3; i++) begin
				if (ctl.sensor == imuds_pkg::SENSOR_MAGNET) begin
					magnet_q[i] <= new_val[i][imuds_pkg::MAG_W-1:0];
				end else begin
					accel_q[i] <= new_val[i];
				end
			end
		end
	end

	assign axis_x = shown[0];
	assign axis_y = shown[1];
	assign axis_z = shown[2];

endmodule

### rtl/imu_sample_decode_smoothing_unit.sv
// Top level of the IMU sample decoder with per-sensor smoothing.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: six raw bytes; tuser: req_type, transfer_error
//   m_axis    out        tdata: axis_x, axis_y, axis_z; tuser: status
//   cfg       in         cfg_index, cfg_data (smoothing weights)
//
// One word per cycle sustained while m_axis_tready stays high.
// The input register feeds one decode and multiply-subtract pass per axis into the
// output register; the filter state updates on the same edge as the output register.
// A stalled output deasserts s_axis_tready once the input register also holds a word.
// Reset clears the filter state, the smoothing weights and both valid flags.
`timescale 1ns / 1ps

module imu_sample_decode_smoothing_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [47:0]                        s_axis_tdata,  // byte_zero .. byte_five
	input  logic [1:0]                         s_axis_tuser,  // req_type, transfer_error
	// Result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [39:0]                        m_axis_tdata,  // axis_x, axis_y, axis_z, pad
	output logic [1:0]                         m_axis_tuser,  // status
	// Configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [imuds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [imuds_pkg::K_W-1:0]          cfg_data
);

	logic                         valid_s1;
	logic                         sensor_s1;
	logic                         xfer_err_s1;
	logic [47:0]                  raw_s1;
	logic                         valid_s2;
	imuds_pkg::status_t           status_s2;
	imuds_pkg::axis_t             x_s2;
	imuds_pkg::axis_t             y_s2;
	imuds_pkg::axis_t             z_s2;
	logic [imuds_pkg::K_W-1:0]    accel_k_q;
	logic [imuds_pkg::K_W-1:0]    magnet_k_q;
	logic                         advance;
	imuds_pkg::decode_t           dec;
	imuds_pkg::filt_ctl_t         ctl;
	imuds_pkg::status_t           status;
	imuds_pkg::axis_t             ax;
	imuds_pkg::axis_t             ay;
	imuds_pkg::axis_t             az;

	// Handshake: the input register moves on whenever the output register can take a word.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_k_q  <= '0;
			magnet_k_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				imuds_pkg::CFG_ACCEL_SMOOTHING:  accel_k_q  <= cfg_data;
				imuds_pkg::CFG_MAGNET_SMOOTHING: magnet_k_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sensor_s1   <= s_axis_tuser[0];
			xfer_err_s1 <= s_axis_tuser[1];
			raw_s1      <= s_axis_tdata;
		end
	end

	imuds_decode u_decode (
		.sensor (sensor_s1),
		.raw    (raw_s1),
		.dec    (dec)
	);

	// Status and update decision for the word in the input register.
	always_comb begin
		if (xfer_err_s1) begin
			status = imuds_pkg::STATUS_XFER_ERR;
		end else if (sensor_s1 == imuds_pkg::SENSOR_MAGNET && !dec.mag_ok) begin
			status = imuds_pkg::STATUS_RANGE;
		end else begin
			status = imuds_pkg::STATUS_OK;
		end
		ctl.update = advance && (status == imuds_pkg::STATUS_OK);
		ctl.sensor = sensor_s1;
	end

	imuds_smooth u_smooth (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.dec      (dec),
		.accel_k  (accel_k_q),
		.magnet_k (magnet_k_q),
		.axis_x   (ax),
		.axis_y   (ay),
		.axis_z   (az)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status;
			x_s2      <= ax;
			y_s2      <= ay;
			z_s2      <= az;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = status_s2;
	assign m_axis_tdata  = {4'h0, z_s2, y_s2, x_s2};

endmodule

### rtl/imuds_checker.sv
// Port-level checks for the IMU sample decoder and the bind that attaches them.
`timescale 1ns / 1ps

module imuds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result word keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
	else $error("result word changed while stalled");

	// Status never carries the unused code.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != imuds_pkg::status_t'(2'd3))
	else $error("invalid status code");

	// With the output register empty, the block always takes input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
	else $error("input blocked while output register empty");

	// Padding bits of the result word stay zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:36] == 4'h0)
	else $error("nonzero padding in result word");

endmodule

bind imu_sample_decode_smoothing_unit imuds_checker u_imuds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
